/* hdl/assert_macros.svh */
// Assertion macros shared by the cache RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// assert that a implies b in the same cycle
`define ASSERT_IMP(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed");
// assert that a implies b in the next cycle
`define ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");
`endif

/* hdl/lkvc_pkg.sv */
// Package: constants and control types of the LRU key-value cache
`timescale 1ns / 1ps
package lkvc_pkg;
   localparam int KEY_SPACE = 1024;
   localparam int KEY_W = 10;
   localparam int MAX_CAP = 16;
   localparam int POS_W = 4;
   localparam int OCC_W = 5;
   localparam int VAL_W = 32;
   localparam logic [VAL_W-1:0] MISS_VALUE = '1;
   localparam logic OP_GET = 1'b0;
   localparam logic OP_PUT = 1'b1;
   localparam logic [OCC_W-1:0] CAP_RESET = 5'd16;

   typedef struct packed {
      logic load;      // capture the request, look up presence
      logic update;    // apply list / presence / value changes
      logic out_load;  // capture result into output register
   } lkvc_cmd_type;
endpackage

/* hdl/lkvc_ram.sv */
// Generic single-port-write, registered-read RAM
`timescale 1ns / 1ps
module lkvc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata <= mem[raddr];
   end
endmodule

/* hdl/lkvc_ctrl.sv */
// Controller: sequences lookup, update and result transfer
`timescale 1ns / 1ps
module lkvc_ctrl import lkvc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output lkvc_cmd_type cmd
);
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_UPD  = 2'd1;
   localparam logic [1:0] ST_OUT  = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       ovalid_ff, ovalid_in;
   logic       out_free;

   assign out_free = !ovalid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = ovalid_ff;

   always_comb begin
      state_in = state_ff;
      ovalid_in = ovalid_ff;
      cmd = '0;
      if (ovalid_ff && rsp_tready) ovalid_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_UPD;
            end
         end
         ST_UPD: begin
            cmd.update = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               ovalid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ovalid_ff <= ovalid_in;
      end
   end

   `include "assert_macros.svh"
   `ASSERT_IMP(a_load_idle, clock, reset, cmd.load, state_ff == ST_IDLE)
   `ASSERT_NEXT(a_load_upd, clock, reset, cmd.load, cmd.update)
   `ASSERT_NEXT(a_out_valid, clock, reset, cmd.out_load, rsp_tvalid)
endmodule

/* hdl/lkvc_dp.sv */
// Datapath: presence match, recency list, value RAM and result register
`timescale 1ns / 1ps
module lkvc_dp import lkvc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  lkvc_cmd_type      cmd,
   input  logic [OCC_W-1:0]  cap,
   input  logic              req_op,
   input  logic [KEY_W-1:0]  req_key,
   input  logic [VAL_W-1:0]  req_value,
   output logic              rsp_hit,
   output logic [VAL_W-1:0]  rsp_read_value,
   output logic              rsp_evicted,
   output logic [KEY_W-1:0]  rsp_evicted_key
);
   logic [KEY_W-1:0]     list_ff [MAX_CAP];
   logic [OCC_W-1:0]     occ_ff;
   logic                 op_ff;
   logic [KEY_W-1:0]     key_ff;
   logic [VAL_W-1:0]     val_ff;
   logic                 hit_ff, ev_ff;
   logic [KEY_W-1:0]     evk_ff;
   logic [MAX_CAP-1:0]   match_ff;
   logic [VAL_W-1:0]     rd_data;
   logic                 o_hit_ff, o_ev_ff;
   logic [VAL_W-1:0]     o_rd_ff;
   logic [KEY_W-1:0]     o_evk_ff;

   logic [OCC_W-1:0]     cap_eff;
   logic                 do_evict, do_insert, ram_we;
   logic [MAX_CAP-1:0]   shift_en;
   logic [MAX_CAP-1:0]   match_in;
   logic [KEY_W-1:0]     last_key;

   assign cap_eff = (cap == '0) ? OCC_W'(1) :
                    (cap > OCC_W'(MAX_CAP)) ? OCC_W'(MAX_CAP) : cap;
   assign last_key = list_ff[POS_W'(occ_ff - OCC_W'(1))];
   assign do_evict = cmd.update && op_ff == OP_PUT && !hit_ff &&
                     occ_ff >= cap_eff && occ_ff != '0;
   assign do_insert = cmd.update && op_ff == OP_PUT && !hit_ff;
   assign ram_we = cmd.update && op_ff == OP_PUT;

   // a key is cached exactly when it sits in the live part of the list
   always_comb begin
      for (int i = 0; i < MAX_CAP; i++)
         match_in[i] = (OCC_W'(i) < occ_ff) && (list_ff[i] == req_key);
   end

   // entries at or below the hit position shift down by one on promote;
   // on insert every entry shifts (an eviction drops the last one anyway)
   always_comb begin
      logic seen;
      seen = 1'b0;
      for (int i = 0; i < MAX_CAP; i++) begin
         if (hit_ff) shift_en[i] = !seen && i != 0;
         else        shift_en[i] = do_insert && i != 0;
         if (match_ff[i]) seen = 1'b1;
      end
   end

   lkvc_ram #(.WIDTH(VAL_W), .DEPTH(KEY_SPACE)) u_vals (
      .clock(clock), .we(ram_we), .waddr(key_ff), .wdata(val_ff),
      .raddr(key_ff), .rdata(rd_data)
   );

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= req_op;
         key_ff <= req_key;
         val_ff <= req_value;
         match_ff <= match_in;
      end
      if (cmd.update) begin
         if (hit_ff || do_insert) begin
            for (int i = 1; i < MAX_CAP; i++)
               if (shift_en[i]) list_ff[i] <= list_ff[i-1];
            list_ff[0] <= key_ff;
         end
         ev_ff <= do_evict;
         evk_ff <= do_evict ? last_key : '0;
      end
      if (cmd.out_load) begin
         o_hit_ff <= hit_ff;
         o_rd_ff <= (op_ff == OP_PUT) ? '0 : (hit_ff ? rd_data : MISS_VALUE);
         o_ev_ff <= ev_ff;
         o_evk_ff <= evk_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
         hit_ff <= 1'b0;
      end else begin
         if (cmd.load) hit_ff <= |match_in;
         if (do_insert && !do_evict) occ_ff <= occ_ff + OCC_W'(1);
      end
   end

   assign rsp_hit = o_hit_ff;
   assign rsp_read_value = o_rd_ff;
   assign rsp_evicted = o_ev_ff;
   assign rsp_evicted_key = o_evk_ff;

   `include "assert_macros.svh"
   `ASSERT_IMP(a_occ_max, clock, reset, 1'b1, occ_ff <= OCC_W'(MAX_CAP))
   `ASSERT_IMP(a_hit_one, clock, reset, cmd.update && hit_ff, $onehot(match_ff))
   `ASSERT_IMP(a_ev_put, clock, reset, do_evict, occ_ff != '0)
endmodule

/* hdl/lru_key_value_cache.sv */
// Top level of the LRU key-value cache: stream ports and register port
// Flow: the request is captured in IDLE (lookup), applied in UPD (update),
// and its result captured in OUT once the output register is free; a new
// request is taken only in IDLE. The recency list shifts in parallel in UPD.
// Reset: occupancy zero so no key is cached, capacity 16; no clearing
// pass, the value memory is read only after it is written.
`timescale 1ns / 1ps
module lru_key_value_cache import lkvc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // op[0], key[10:1], value[42:11], zero fill
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // hit[0], read_value[32:1], evicted[33], evicted_key[43:34]
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   localparam logic [2:0] ADDR_CAPACITY = 3'd0;

   logic [OCC_W-1:0] cap_ff;
   lkvc_cmd_type cmd;
   logic hit, ev;
   logic [VAL_W-1:0] rdv;
   logic [KEY_W-1:0] evk;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == ADDR_CAPACITY) ? {27'd0, cap_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) cap_ff <= CAP_RESET;
      else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == ADDR_CAPACITY)
         cap_ff <= csr_pwdata[OCC_W-1:0];
   end

   lkvc_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .cmd(cmd)
   );

   lkvc_dp u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .cap(cap_ff),
      .req_op(req_tdata[0]), .req_key(req_tdata[10:1]), .req_value(req_tdata[42:11]),
      .rsp_hit(hit), .rsp_read_value(rdv), .rsp_evicted(ev), .rsp_evicted_key(evk)
   );

   assign rsp_tdata = {4'd0, evk, ev, rdv, hit};
endmodule

/* tb/lru_key_value_cache_test.sv */
// Testbench for the LRU key-value cache: predicts every result and checks it
`timescale 1ns / 1ps
module lru_key_value_cache_test;
   import lkvc_pkg::*;

   typedef struct packed {
      logic             hit;
      logic [VAL_W-1:0] read_value;
      logic             evicted;
      logic [KEY_W-1:0] evicted_key;
   } lookup_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   localparam logic [2:0] ADDR_CAPACITY = 3'd0;

   lru_key_value_cache i_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // cache shadow
   logic [4:0]       cache_cap;
   logic             key_present [KEY_SPACE];
   logic [VAL_W-1:0] key_value [KEY_SPACE];
   logic [KEY_W-1:0] recency [MAX_CAP];
   int               occ;

   logic [47:0]       pending_reqs [$];
   lookup_result_type expected_rsps [$];
   int  error_count = 0;
   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   int  cycle_count = 0;
   logic driving = 1'b0;
   logic req_accepted = 1'b0;

   function automatic lookup_result_type predict_access(logic op, logic [KEY_W-1:0] k,
                                                        logic [VAL_W-1:0] v);
      lookup_result_type r;
      int eff, pos;
      logic [KEY_W-1:0] t;
      eff = (cache_cap < 1) ? 1 : (cache_cap > MAX_CAP) ? MAX_CAP : cache_cap;
      r = '0;
      r.hit = key_present[k];
      pos = -1;
      for (int i = 0; i < occ; i++) if (pos < 0 && recency[i] == k) pos = i;
      if (r.hit) begin
         if (op == OP_GET) r.read_value = key_value[k];
         else key_value[k] = v;
         t = recency[pos];
         for (int i = pos; i > 0; i--) recency[i] = recency[i-1];
         recency[0] = t;
      end else if (op == OP_GET) begin
         r.read_value = MISS_VALUE;
      end else begin
         if (occ >= eff && occ > 0) begin
            r.evicted = 1'b1;
            r.evicted_key = recency[occ-1];
            key_present[recency[occ-1]] = 1'b0;
            occ--;
         end
         if (occ < MAX_CAP) begin
            for (int i = occ; i > 0; i--) recency[i] = recency[i-1];
            recency[0] = k;
            occ++;
            key_present[k] = 1'b1;
            key_value[k] = v;
         end
      end
      return r;
   endfunction

   task automatic queue_access(logic op, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
      pending_reqs.push_back({5'b0, v, k, op});
      expected_rsps.push_back(predict_access(op, k, v));
   endtask

   task automatic report_mismatch(string what, logic [47:0] got, logic [47:0] want);
      $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycle_count);
      error_count++;
   endtask

   // request transfer seen at the rising edge
   always @(posedge clock) begin
      req_accepted <= !reset && req_tvalid && req_tready;
   end

   // driver
   always @(negedge clock) begin
      if (!reset) begin
         if (req_accepted) begin
            void'(pending_reqs.pop_front());
         end
         if (driving && pending_reqs.size() > 0 &&
             ((req_tvalid && !req_accepted) || ($urandom_range(99) >= send_idle_pct))) begin
            req_tvalid <= 1'b1;
            req_tdata <= pending_reqs[0];
         end else begin
            req_tvalid <= 1'b0;
         end
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // monitor
   always @(posedge clock) begin
      lookup_result_type got, want;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = lookup_result_type'({rsp_tdata[0], rsp_tdata[32:1], rsp_tdata[33],
                                    rsp_tdata[43:34]});
         if (expected_rsps.size() == 0) begin
            report_mismatch("unexpected transfer", rsp_tdata, '0);
         end else begin
            want = expected_rsps.pop_front();
            if (got.hit != want.hit) report_mismatch("hit", got.hit, want.hit);
            if (got.read_value != want.read_value)
               report_mismatch("read_value", got.read_value, want.read_value);
            if (got.evicted != want.evicted)
               report_mismatch("evicted", got.evicted, want.evicted);
            if (got.evicted_key != want.evicted_key)
               report_mismatch("evicted_key", got.evicted_key, want.evicted_key);
         end
      end
      if (cycle_count > 1000000) begin
         $display("lru_key_value_cache_test: done, errors");
         $finish;
      end
   end

   task automatic drain();
      while (pending_reqs.size() > 0 || req_tvalid || expected_rsps.size() > 0)
         @(negedge clock);
      driving = 1'b0;
      repeat (8) @(negedge clock);
   endtask

   task automatic write_capacity(logic [31:0] val);
      @(negedge clock);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_paddr <= ADDR_CAPACITY;
      csr_pwdata <= val;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      cache_cap = val[4:0];
   endtask

   task automatic run_random(int n, int key_hi);
      logic op;
      for (int i = 0; i < n; i++) begin
         op = 1'($urandom_range(1));
         queue_access(op, (key_hi >= 1023) ? KEY_W'($urandom) : KEY_W'($urandom_range(key_hi)),
                      $urandom);
      end
      driving = 1'b1;
      drain();
   endtask

   initial begin
      cache_cap = CAP_RESET;
      occ = 0;
      for (int i = 0; i < KEY_SPACE; i++) begin
         key_present[i] = 1'b0;
         key_value[i] = '0;
      end
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      rsp_tready <= 1'b1;

      // directed: extremes of keys and values, misses, hits, refresh, eviction
      queue_access(OP_GET, 10'd0, 32'h0);
      queue_access(OP_PUT, 10'd0, 32'h7fffffff);
      queue_access(OP_PUT, 10'd1023, 32'h80000000);
      queue_access(OP_GET, 10'd0, 32'hffffffff);
      queue_access(OP_GET, 10'd1023, 32'h0);
      queue_access(OP_PUT, 10'd0, 32'hffffffff);
      queue_access(OP_GET, 10'd0, 32'h0);
      queue_access(OP_GET, 10'd5, 32'h0);
      driving = 1'b1;
      drain();
      write_capacity(32'd1);           // lower than occupancy
      queue_access(OP_PUT, 10'd7, 32'h12345678);
      queue_access(OP_PUT, 10'd8, 32'h0);
      queue_access(OP_GET, 10'd7, 32'h0);
      queue_access(OP_GET, 10'd8, 32'h0);
      driving = 1'b1;
      drain();
      write_capacity(32'd0);           // zero acts as one
      queue_access(OP_PUT, 10'd9, 32'h55aa55aa);
      queue_access(OP_GET, 10'd8, 32'h0);
      driving = 1'b1;
      drain();
      write_capacity(32'h1f);          // above max acts as max
      queue_access(OP_PUT, 10'd3, 32'h1);
      driving = 1'b1;
      drain();

      // random phases with varying idling and capacity
      send_idle_pct = 0;  recv_stall_pct = 0;  write_capacity(32'd16); run_random(400, 31);
      send_idle_pct = 87; recv_stall_pct = 0;  write_capacity(32'd4);  run_random(250, 15);
      send_idle_pct = 0;  recv_stall_pct = 87; write_capacity(32'd1);  run_random(250, 7);
      send_idle_pct = 20; recv_stall_pct = 20; write_capacity(32'd9);  run_random(400, 1023);
      send_idle_pct = 0;  recv_stall_pct = 0;  write_capacity(32'd16); run_random(400, 20);

      if (error_count == 0) begin
         $display("lru_key_value_cache_test: done, clean");
      end else begin
         $display("lru_key_value_cache_test: done, errors");
      end
      $finish;
   end
endmodule

/* files.f */
+incdir+hdl
hdl/lkvc_pkg.sv
hdl/lkvc_ram.sv
hdl/lkvc_ctrl.sv
hdl/lkvc_dp.sv
hdl/lru_key_value_cache.sv
tb/lru_key_value_cache_test.sv
